// ===== src/c_token_lexer_macros.svh =====
// assertion macros for the c token lexer
`ifndef C_TOKEN_LEXER_MACROS_SVH
`define C_TOKEN_LEXER_MACROS_SVH

// same-cycle implication
`define CTL_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CTL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/ctl_pkg.sv =====
// shared types, constants and literal table for the c token lexer
package ctl_pkg;

   localparam int LA_DEPTH = 16;
   localparam int LA_CW    = $clog2(LA_DEPTH + 1);
   localparam int LA_IW    = $clog2(LA_DEPTH);
   localparam int NUM_LITS = 74;
   localparam int LIT_MAX  = 14;
   localparam int LIT_LW   = $clog2(LIT_MAX + 1);

   localparam logic [6:0]  KIND_NUMBER = 7'd74;
   localparam logic [6:0]  KIND_IDENT  = 7'd75;
   localparam logic [15:0] LEN_MAX     = 16'hFFFF;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [6:0]  token_kind;
      logic [31:0] token_line;
      logic [31:0] token_column;
      logic [15:0] token_length;
      logic        last_of_run;
   } rsp_type;

   typedef enum logic [2:0] {
      CLS_OTHER,
      CLS_NL,
      CLS_BLANK,
      CLS_DIGIT,
      CLS_ALPHA
   } cls_type;

   typedef enum logic [1:0] {
      RUN_NONE,
      RUN_NUM,
      RUN_IDENT
   } run_type;

   typedef struct packed {
      logic [7:0] ch;
      cls_type    cls;
      logic       fin;
   } beat_type;

   typedef struct packed {
      logic [7:0] ch;
      cls_type    cls;
   } la_type;

   localparam logic [8*LIT_MAX-1:0] LIT_TEXT [NUM_LITS] = '{
      "auto", "break", "case", "char", "const", "continue", "default", "do",
      "else", "enum", "extern", "for", "goto", "if", "inline", "int", "long",
      "register", "restrict", "return", "short", "signed", "sizeof", "static",
      "struct", "switch", "typedef", "union", "unsigned", "void", "volatile",
      "while", "_Alignas", "_Alignof", "_Atomic", "_Bool", "_Complex",
      "_Generic", "_Imaginary", "_Noreturn", {"_Static", "_assert"},
      {"_Thread", "_local"},
      "<<", ">>", ">=", "<=", "==", "=", "+=", "-=", "&=", "|=", "^=", "~=",
      "*=", "/=", "%=", "*", "&", "|", "^", "~", "/", "%", "++", "+", "--",
      "-", "{", "}", "[", "]", "(", ")"
   };

   function automatic int lit_count(int i);
      int n;
      n = 0;
      for (int k = 0; k < LIT_MAX; k++) begin
         if (LIT_TEXT[i][8*k +: 8] != 8'd0) n = n + 1;
      end
      return n;
   endfunction

   function automatic logic [LIT_LW-1:0] lit_len(int i);
      return LIT_LW'(lit_count(i));
   endfunction

   // strings are right-justified, so the first character sits highest
   function automatic logic [7:0] lit_byte(int i, int j);
      int n;
      logic [7:0] b;
      n = lit_count(i);
      b = 8'd0;
      if (j < n) b = LIT_TEXT[i][8*(n-1-j) +: 8];
      return b;
   endfunction

   function automatic logic [31:0] sat_add(logic [31:0] a, logic [15:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {17'd0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

endpackage

// ===== src/c_token_lexer.sv =====
// c token lexer top level: input queue, resolve engine and checks
//
// text enters on the req_ channel one byte per beat; end_of_text marks the
// last byte of a text and flushes whatever is still pending. tokens leave on
// the rsp_ channel as kind, line, column and length, with last_of_run set on
// the final token caused by a given byte. a byte may cause no token, one, or
// several; bytes that can still grow into a keyword or operator wait in a
// 16-entry lookahead and are resolved by a later byte.
// a byte that only waits in the lookahead is loaded from the two-entry input
// queue in one engine step and releases its last token in another. every match
// step (a token, a run close, a run byte, a blank, a newline or a skipped byte)
// is a step of its own, so a plain byte is loaded, matched and then released.
// each token is registered in a hold slot and then in the output register.
// a stalled rsp_ready holds the output register and the engine stops at its
// next token; the input queue keeps taking bytes until it is full.
// reset is synchronous and clears line, column, runs and the lookahead.
`include "c_token_lexer_macros.svh"

module c_token_lexer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ctl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ctl_pkg::rsp_type rsp_data
);
   import ctl_pkg::*;

   logic     q_vld;
   logic     q_pop;
   beat_type q_data;

   ctl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_vld     (q_vld),
      .q_data    (q_data),
      .q_pop     (q_pop)
   );

   ctl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_vld     (q_vld),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   `CTL_ASSERT_IMP(a_pop_has_beat, q_pop, q_vld, "pop from empty queue")
   `CTL_ASSERT_NEXT(a_beat_kept, q_vld && !q_pop, q_vld, "queued beat lost")
   `CTL_ASSERT_NEXT(a_push_lands, req_valid && req_ready, q_vld, "accepted beat not queued")

endmodule

// ===== src/ctl_front.sv =====
// input side: byte classification and a two-entry beat queue
module ctl_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ctl_pkg::req_type  req_data,
   output logic              q_vld,
   output ctl_pkg::beat_type q_data,
   input  logic              q_pop
);
   import ctl_pkg::*;

   beat_type   mem_ff [2];
   logic       wp_ff, wp_in;
   logic       rp_ff, rp_in;
   logic [1:0] num_ff, num_in;
   logic       push;
   beat_type   beat;

   function automatic cls_type classify(logic [7:0] c);
      cls_type r;
      r = CLS_OTHER;
      if (c == 8'h0A) r = CLS_NL;
      else if (c == 8'h20 || c == 8'h09) r = CLS_BLANK;
      else if (c >= 8'h30 && c <= 8'h39) r = CLS_DIGIT;
      else if (c >= 8'h61 && c <= 8'h7A) r = CLS_ALPHA;
      return r;
   endfunction

   assign req_ready = (num_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_vld     = (num_ff != 2'd0);
   assign q_data    = mem_ff[rp_ff];

   always_comb begin
      beat.ch  = req_data.char_code;
      beat.cls = classify(req_data.char_code);
      beat.fin = req_data.end_of_text;
      wp_in    = push ? ~wp_ff : wp_ff;
      rp_in    = q_pop ? ~rp_ff : rp_ff;
      num_in   = num_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= beat;
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         num_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         num_ff <= num_in;
      end
   end

endmodule

// ===== src/ctl_back.sv =====
// resolve engine: lookahead, literal match, runs, counters and result register
module ctl_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_vld,
   input  ctl_pkg::beat_type q_data,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ctl_pkg::rsp_type  rsp_data
);
   import ctl_pkg::*;

   typedef enum logic {ST_IDLE, ST_STEP} state_type;

   state_type         state_ff, state_in;
   la_type            la_ff [LA_DEPTH];
   la_type            la_in [LA_DEPTH];
   logic [LA_CW-1:0]  cnt_ff, cnt_in;
   logic [31:0]       line_ff, line_in;
   logic [31:0]       col_ff, col_in;
   run_type           run_ff, run_in;
   logic [15:0]       rlen_ff, rlen_in;
   logic [31:0]       rstart_ff, rstart_in;
   logic              fin_ff, fin_in;
   rsp_type           hold_ff, hold_in;
   logic              hold_vld_ff, hold_vld_in;
   rsp_type           out_ff, out_in;
   logic              out_vld_ff, out_vld_in;

   logic [NUM_LITS-1:0] full, part;
   logic              lit_hit, lit_wait, found;
   logic [6:0]        lit_idx;
   logic [LIT_LW-1:0] lit_ln;
   logic              out_free, emit_ok, em, in_run;
   logic [6:0]        em_kind;
   logic [31:0]       em_col;
   logic [15:0]       em_len;
   logic [LIT_LW-1:0] drop;
   logic [LA_CW:0]    src;

   // literal matching against the lookahead
   always_comb begin
      for (int i = 0; i < NUM_LITS; i++) begin
         full[i] = (cnt_ff >= LA_CW'(lit_len(i)));
         part[i] = (cnt_ff < LA_CW'(lit_len(i)));
         for (int j = 0; j < LIT_MAX; j++) begin
            if (j < lit_count(i) && la_ff[j].ch != lit_byte(i, j)) begin
               full[i] = 1'b0;
               if (LA_CW'(j) < cnt_ff) part[i] = 1'b0;
            end
         end
      end
      lit_hit  = 1'b0;
      lit_wait = 1'b0;
      found    = 1'b0;
      lit_idx  = 7'd0;
      lit_ln   = '0;
      for (int i = 0; i < NUM_LITS; i++) begin
         if (!found && (full[i] || (part[i] && !fin_ff))) begin
            found    = 1'b1;
            lit_hit  = full[i];
            lit_wait = !full[i];
            lit_idx  = 7'(i);
            lit_ln   = lit_len(i);
         end
      end
   end

   assign in_run = (run_ff == RUN_NUM && la_ff[0].cls == CLS_DIGIT) ||
                   (run_ff == RUN_IDENT && la_ff[0].cls == CLS_ALPHA);

   always_comb begin
      state_in    = state_ff;
      la_in       = la_ff;
      cnt_in      = cnt_ff;
      line_in     = line_ff;
      col_in      = col_ff;
      run_in      = run_ff;
      rlen_in     = rlen_ff;
      rstart_in   = rstart_ff;
      fin_in      = fin_ff;
      hold_in     = hold_ff;
      hold_vld_in = hold_vld_ff;
      out_free    = !out_vld_ff || rsp_ready;
      emit_ok     = !hold_vld_ff || out_free;
      out_in      = out_ff;
      out_vld_in  = out_vld_ff && !rsp_ready;
      q_pop       = 1'b0;
      em          = 1'b0;
      em_kind     = 7'd0;
      em_col      = 32'd0;
      em_len      = 16'd0;
      drop        = '0;
      src         = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_vld) begin
               q_pop = 1'b1;
               if (cnt_ff < LA_CW'(LA_DEPTH)) begin
                  la_in[cnt_ff[LA_IW-1:0]] = '{ch: q_data.ch, cls: q_data.cls};
                  cnt_in = cnt_ff + LA_CW'(1);
               end
               fin_in   = q_data.fin;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            priority if (cnt_ff != '0 && run_ff != RUN_NONE) begin
               if (in_run) begin
                  if (rlen_ff != LEN_MAX) rlen_in = rlen_ff + 16'd1;
                  col_in = sat_add(col_ff, 16'd1);
                  drop   = LIT_LW'(1);
               end else begin
                  em      = 1'b1;
                  em_kind = (run_ff == RUN_NUM) ? KIND_NUMBER : KIND_IDENT;
                  em_col  = rstart_ff;
                  em_len  = rlen_ff;
                  if (emit_ok) begin
                     run_in  = RUN_NONE;
                     rlen_in = 16'd0;
                  end
               end
            end else if (cnt_ff != '0 && !lit_wait) begin
               if (lit_hit) begin
                  em      = 1'b1;
                  em_kind = lit_idx;
                  em_col  = col_ff;
                  em_len  = {{(16-LIT_LW){1'b0}}, lit_ln};
                  if (emit_ok) begin
                     col_in = sat_add(col_ff, em_len);
                     drop   = lit_ln;
                  end
               end else begin
                  drop = LIT_LW'(1);
                  unique case (la_ff[0].cls)
                     CLS_NL: begin
                        line_in = sat_add(line_ff, 16'd1);
                        col_in  = 32'd0;
                     end
                     CLS_BLANK: col_in = sat_add(col_ff, 16'd1);
                     CLS_DIGIT, CLS_ALPHA: begin
                        run_in    = (la_ff[0].cls == CLS_DIGIT) ? RUN_NUM : RUN_IDENT;
                        rlen_in   = 16'd1;
                        rstart_in = col_ff;
                        col_in    = sat_add(col_ff, 16'd1);
                     end
                     default: ;
                  endcase
               end
            end else if (fin_ff && run_ff != RUN_NONE) begin
               em      = 1'b1;
               em_kind = (run_ff == RUN_NUM) ? KIND_NUMBER : KIND_IDENT;
               em_col  = rstart_ff;
               em_len  = rlen_ff;
               if (emit_ok) begin
                  run_in  = RUN_NONE;
                  rlen_in = 16'd0;
               end
            end else begin
               if (emit_ok) begin
                  if (hold_vld_ff) begin
                     out_in             = hold_ff;
                     out_in.last_of_run = 1'b1;
                     out_vld_in         = 1'b1;
                  end
                  hold_vld_in = 1'b0;
                  if (fin_ff) begin
                     cnt_in    = '0;
                     line_in   = 32'd0;
                     col_in    = 32'd0;
                     rstart_in = 32'd0;
                  end
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // token goes to the hold slot, the previous one moves out as a non-final beat
      if (em && emit_ok) begin
         if (hold_vld_ff) begin
            out_in             = hold_ff;
            out_in.last_of_run = 1'b0;
            out_vld_in         = 1'b1;
         end
         hold_in.token_kind   = em_kind;
         hold_in.token_line   = line_ff;
         hold_in.token_column = em_col;
         hold_in.token_length = em_len;
         hold_in.last_of_run  = 1'b0;
         hold_vld_in          = 1'b1;
      end

      if (drop != '0) begin
         for (int k = 0; k < LA_DEPTH; k++) begin
            src = (LA_CW+1)'(k) + {{(LA_CW+1-LIT_LW){1'b0}}, drop};
            if (src < (LA_CW+1)'(LA_DEPTH)) la_in[k] = la_ff[src[LA_IW-1:0]];
         end
         cnt_in = cnt_ff - {{(LA_CW-LIT_LW){1'b0}}, drop};
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      la_ff   <= la_in;
      fin_ff  <= fin_in;
      hold_ff <= hold_in;
      out_ff  <= out_in;
      if (reset) begin
         state_ff    <= ST_IDLE;
         cnt_ff      <= '0;
         line_ff     <= 32'd0;
         col_ff      <= 32'd0;
         run_ff      <= RUN_NONE;
         rlen_ff     <= 16'd0;
         rstart_ff   <= 32'd0;
         hold_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         line_ff     <= line_in;
         col_ff      <= col_in;
         run_ff      <= run_in;
         rlen_ff     <= rlen_in;
         rstart_ff   <= rstart_in;
         hold_vld_ff <= hold_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

endmodule

// ===== bench/c_token_lexer_checker.sv =====
// token predictor and scoreboard for the c token lexer bench
module c_token_lexer_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  ctl_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  ctl_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending_count
);
   import ctl_pkg::*;

   logic [7:0]  pend_bytes [$];
   logic [31:0] line_cnt, col_cnt, run_col;
   run_type     run_cls;
   logic [15:0] run_len;
   rsp_type     token_queue [$];
   rsp_type     byte_tokens [$];

   function automatic logic [31:0] inc32(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic void add_token(logic [6:0] k, logic [31:0] c, logic [31:0] n);
      rsp_type t;
      if (byte_tokens.size() >= 16) return;
      t.token_kind   = k;
      t.token_line   = line_cnt;
      t.token_column = c;
      t.token_length = (n > 32'hFFFF) ? 16'hFFFF : n[15:0];
      t.last_of_run  = 1'b0;
      byte_tokens.insert(byte_tokens.size(), t);
   endfunction

   function automatic void close_run();
      if (run_cls == RUN_NUM) add_token(KIND_NUMBER, run_col, {16'd0, run_len});
      else if (run_cls == RUN_IDENT) add_token(KIND_IDENT, run_col, {16'd0, run_len});
      run_cls = RUN_NONE;
      run_len = 16'd0;
   endfunction

   // 0 no literal, 1 match, 2 wait for more
   function automatic int match_literal(bit fin, output int kind, output int len);
      int j, n;
      kind = 0;
      len = 0;
      for (int i = 0; i < NUM_LITS; i++) begin
         n = lit_count(i);
         j = 0;
         while (j < n && j < pend_bytes.size() && pend_bytes[j] == lit_byte(i, j)) j++;
         if (j == n) begin
            kind = i;
            len = j;
            return 1;
         end
         if (j == pend_bytes.size() && !fin) return 2;
      end
      return 0;
   endfunction

   function automatic bit run_fits(logic [7:0] c);
      if (run_cls == RUN_NUM) return c >= "0" && c <= "9";
      if (run_cls == RUN_IDENT) return c >= "a" && c <= "z";
      return 0;
   endfunction

   function automatic void start_run(run_type r);
      run_cls = r;
      run_len = 16'd1;
      run_col = col_cnt;
      col_cnt = inc32(col_cnt, 32'd1);
   endfunction

   function automatic void lex_byte(req_type rq);
      logic [7:0] c;
      int r, kind, len;
      byte_tokens.delete();
      if (pend_bytes.size() < LA_DEPTH) pend_bytes.insert(pend_bytes.size(), rq.char_code);
      while (pend_bytes.size() > 0) begin
         c = pend_bytes[0];
         if (run_cls != RUN_NONE) begin
            if (run_fits(c)) begin
               if (run_len != 16'hFFFF) run_len++;
               col_cnt = inc32(col_cnt, 32'd1);
               void'(pend_bytes.pop_front());
            end else close_run();
            continue;
         end
         r = match_literal(rq.end_of_text, kind, len);
         if (r == 2) break;
         if (r == 1) begin
            add_token(kind[6:0], col_cnt, 32'(len));
            col_cnt = inc32(col_cnt, 32'(len));
            for (int i = 0; i < len; i++) void'(pend_bytes.pop_front());
            continue;
         end
         if (c == 8'h0A) begin
            line_cnt = inc32(line_cnt, 32'd1);
            col_cnt = 32'd0;
         end else if (c == " " || c == 8'h09) col_cnt = inc32(col_cnt, 32'd1);
         else if (c >= "0" && c <= "9") start_run(RUN_NUM);
         else if (c >= "a" && c <= "z") start_run(RUN_IDENT);
         void'(pend_bytes.pop_front());
      end
      if (rq.end_of_text) begin
         close_run();
         pend_bytes.delete();
         line_cnt = 32'd0;
         col_cnt = 32'd0;
         run_col = 32'd0;
      end
      if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size()-1].last_of_run = 1'b1;
      foreach (byte_tokens[i]) token_queue.insert(token_queue.size(), byte_tokens[i]);
   endfunction

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         pend_bytes.delete();
         token_queue.delete();
         col_cnt = 32'd0;
         line_cnt = 32'd0;
         run_col = 32'd0;
         run_cls = RUN_NONE;
         run_len = 16'd0;
         fail_count <= 0;
      end else begin
         if (req_valid && req_ready) lex_byte(req_data);
         if (rsp_valid && rsp_ready) begin
            if (token_queue.size() == 0) begin
               $error("unexpected token beat kind=%0d", rsp_data.token_kind);
               fail_count <= fail_count + 1;
            end else begin
               e = token_queue.pop_front();
               if (e !== rsp_data) begin
                  if (e.token_kind !== rsp_data.token_kind)
                     $error("token_kind exp %0d got %0d", e.token_kind, rsp_data.token_kind);
                  if (e.token_line !== rsp_data.token_line)
                     $error("token_line exp %0d got %0d", e.token_line, rsp_data.token_line);
                  if (e.token_column !== rsp_data.token_column)
                     $error("token_column exp %0d got %0d", e.token_column,
                            rsp_data.token_column);
                  if (e.token_length !== rsp_data.token_length)
                     $error("token_length exp %0d got %0d", e.token_length,
                            rsp_data.token_length);
                  if (e.last_of_run !== rsp_data.last_of_run)
                     $error("last_of_run exp %0d got %0d", e.last_of_run,
                            rsp_data.last_of_run);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending_count = token_queue.size();
   end
endmodule

// ===== bench/c_token_lexer_tb.sv =====
// testbench top for the c token lexer: stimulus, stalls and verdict
module c_token_lexer_tb;
   import ctl_pkg::*;

   localparam int STALL_LIMIT = 20000;
   localparam int HOLD_CYCLES = 150;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 0;
   rsp_type rsp_data;
   int      fail_count, pending_count;
   int      send_idle_pct = 18, recv_idle_pct = 61;
   bit      hold_req = 0, hold_taken = 0;
   int      hold_left = 0;
   int      quiet_cycles = 0;
   string   words [$] = '{
      "auto ", {"_Static", "_assert"}, {"_Thread", "_local"}, "continue", "ifx", "<<=",
      ">>", "a+=b", "x++ --y", "{[()]}", "~=", "^", "%=", "123 abc",
      "returnx", "_Alig", "int\tz", "cont", "/=*", "&|", "==", "q\n"
   };

   always #5 clock = ~clock;

   c_token_lexer i_dut (.*);

   c_token_lexer_checker i_checker (.*);

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // receiver: random idling, plus one long hold counted here
   always @(negedge clock) begin
      if (hold_req && !hold_taken) begin
         hold_taken <= 1;
         hold_left  <= HOLD_CYCLES;
         rsp_ready  <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 0;
      end else rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_byte(logic [7:0] c, bit fin);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
         while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      end
      req_valid <= 1;
      req_data <= '{char_code: c, end_of_text: fin};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_text(string s, bit fin);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], fin && i == s.len() - 1);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pending_count != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   function automatic logic [7:0] pick_char();
      string alpha = "abcdefgirstuvwxyz0123456789 \t\n<>=+-*/%&|^~{}[]()_ACSTB";
      int r;
      r = $urandom_range(99);
      if (r < 8) return 8'($urandom_range(255));
      return alpha[$urandom_range(alpha.len() - 1)];
   endfunction

   task automatic random_part(int count);
      int n;
      n = 0;
      while (n < count) begin
         if ($urandom_range(3) == 0) begin
            send_text(words[$urandom_range(words.size() - 1)], 0);
            n += 4;
         end else begin
            send_byte(pick_char(), $urandom_range(29) == 0);
            n++;
         end
      end
      send_byte(" ", 1);
   endtask

   initial begin
      repeat (2) @(negedge clock);
      reset <= 0;
      send_text("ifx _Static", 0);
      send_text("_assert\n", 0);
      send_byte(8'h00, 0);
      send_byte(8'hFF, 0);
      send_text("<<=9 ^ _Th", 1);
      drain();
      hold_req = 1;
      for (int i = 0; i < 16; i++) send_byte(pick_char(), 0);
      send_byte(" ", 1);
      drain();
      random_part(105);
      drain();
      send_idle_pct = 61;
      recv_idle_pct = 18;
      random_part(105);
      drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_part(105);
      drain();
      if (fail_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end
endmodule
